[rtl/apq_pkg.sv]
// Shared types and constants for the array priority queue.
`timescale 1ns / 1ps

package apq_pkg;

  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int ENTRY_W  = DATA_W + PRIO_W;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT_START,
    S_SHIFT,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic                latch_in;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                enq_write;
    logic                scan_start;
    logic                scan_step;
    logic                take_best;
    logic                shift_start;
    logic                shift_step;
    logic                count_dec;
    logic                load_out;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
    logic scan_last;
    logic best_is_last;
    logic shift_last;
  } stat_t;

endpackage

[rtl/apq_ctrl.sv]
// Sequencer for enqueue, scan and shift phases of the priority queue.
`timescale 1ns / 1ps

module apq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  apq_pkg::stat_t stat,
  output apq_pkg::ctrl_t ctrl
);

  apq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == apq_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      apq_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = apq_pkg::S_EXEC;
      end
      apq_pkg::S_EXEC: begin
        if (stat.is_deq && !stat.empty) state_nxt = apq_pkg::S_SCAN;
        else state_nxt = apq_pkg::S_RESULT;
      end
      apq_pkg::S_SCAN: begin
        if (stat.scan_last) state_nxt = apq_pkg::S_SHIFT_START;
      end
      apq_pkg::S_SHIFT_START: begin
        if (stat.best_is_last) state_nxt = apq_pkg::S_RESULT;
        else state_nxt = apq_pkg::S_SHIFT;
      end
      apq_pkg::S_SHIFT: begin
        if (stat.shift_last) state_nxt = apq_pkg::S_RESULT;
      end
      apq_pkg::S_RESULT: begin
        if (out_free) state_nxt = apq_pkg::S_IDLE;
      end
      default: state_nxt = apq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      apq_pkg::S_IDLE: begin
        ctrl.latch_in = in_tvalid;
      end
      apq_pkg::S_EXEC: begin
        ctrl.set_status = 1'b1;
        if (!stat.is_deq) begin
          if (stat.full) begin
            ctrl.status = apq_pkg::ST_OVERFLOW;
          end else begin
            ctrl.status    = apq_pkg::ST_OK;
            ctrl.enq_write = 1'b1;
          end
        end else if (stat.empty) begin
          ctrl.status = apq_pkg::ST_UNDERFLOW;
        end else begin
          ctrl.status     = apq_pkg::ST_OK;
          ctrl.scan_start = 1'b1;
        end
      end
      apq_pkg::S_SCAN: begin
        ctrl.scan_step = 1'b1;
      end
      apq_pkg::S_SHIFT_START: begin
        ctrl.take_best = 1'b1;
        if (stat.best_is_last) ctrl.count_dec = 1'b1;
        else ctrl.shift_start = 1'b1;
      end
      apq_pkg::S_SHIFT: begin
        ctrl.shift_step = 1'b1;
        ctrl.count_dec  = stat.shift_last;
      end
      apq_pkg::S_RESULT: begin
        ctrl.load_out = out_free;
      end
      default: ctrl = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/apq_datapath.sv]
// Entry memory, count, max scan and shift datapath of the priority queue.
`timescale 1ns / 1ps

module apq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  apq_pkg::ctrl_t                      ctrl,
  output apq_pkg::stat_t                      stat,
  input  logic                                in_command,
  input  logic signed [apq_pkg::DATA_W-1:0]   in_item_data,
  input  logic signed [apq_pkg::PRIO_W-1:0]   in_item_priority,
  output logic [apq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [apq_pkg::DATA_W-1:0]   out_data,
  output logic signed [apq_pkg::PRIO_W-1:0]   out_priority,
  output logic [apq_pkg::COUNT_W-1:0]         out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [apq_pkg::ENTRY_W-1:0] mem [DEPTH];

  logic                               cmd_r;
  logic signed [apq_pkg::DATA_W-1:0]  data_in_r;
  logic signed [apq_pkg::PRIO_W-1:0]  prio_in_r;
  logic [CW-1:0]                      count_r, count_nxt;
  logic [AW-1:0]                      idx_r, idx_nxt;
  logic [AW-1:0]                      best_idx_r;
  logic signed [apq_pkg::DATA_W-1:0]  best_data_r;
  logic signed [apq_pkg::PRIO_W-1:0]  best_prio_r;
  logic [apq_pkg::ENTRY_W-1:0]        rd_data_r;
  logic [apq_pkg::STATUS_W-1:0]       res_status_r;
  logic signed [apq_pkg::DATA_W-1:0]  res_data_r;
  logic signed [apq_pkg::PRIO_W-1:0]  res_prio_r;
  logic [apq_pkg::STATUS_W-1:0]       out_status_r;
  logic signed [apq_pkg::DATA_W-1:0]  out_data_r;
  logic signed [apq_pkg::PRIO_W-1:0]  out_prio_r;
  logic [apq_pkg::COUNT_W-1:0]        out_count_r;

  logic [CW-1:0]                      idx_c;
  logic [CW-1:0]                      count_m1;
  logic signed [apq_pkg::DATA_W-1:0]  rd_val;
  logic signed [apq_pkg::PRIO_W-1:0]  rd_prio;
  logic                               take;
  logic                               rd_en;
  logic [CW-1:0]                      rd_addr_c;
  logic [AW-1:0]                      rd_addr;
  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  logic [apq_pkg::ENTRY_W-1:0]        wr_data;
  logic [CW+apq_pkg::COUNT_W-1:0]     count_wide;

  // entry layout: priority in the upper bits, data in the lower bits
  assign idx_c    = CW'(idx_r);
  assign count_m1 = count_r - CW'(1);
  assign rd_val   = rd_data_r[apq_pkg::DATA_W-1:0];
  assign rd_prio  = rd_data_r[apq_pkg::ENTRY_W-1:apq_pkg::DATA_W];

  assign stat.is_deq       = (cmd_r == apq_pkg::CMD_DEQUEUE);
  assign stat.full         = (count_r == CW'(DEPTH));
  assign stat.empty        = (count_r == '0);
  assign stat.scan_last    = (idx_c == count_m1);
  assign stat.best_is_last = (CW'(best_idx_r) == count_m1);
  assign stat.shift_last   = ((idx_c + CW'(2)) == count_r);

  // strict compare keeps the earliest entry among equal priorities
  assign take = ctrl.scan_step && ((idx_r == '0) || (rd_prio > best_prio_r));

  always_comb begin
    rd_en     = 1'b0;
    rd_addr_c = '0;
    if (ctrl.scan_start) begin
      rd_en = 1'b1;
    end else if (ctrl.scan_step) begin
      rd_addr_c = idx_c + CW'(1);
      rd_en     = (rd_addr_c < count_r);
    end else if (ctrl.shift_start) begin
      rd_addr_c = CW'(best_idx_r) + CW'(1);
      rd_en     = 1'b1;
    end else if (ctrl.shift_step) begin
      rd_addr_c = idx_c + CW'(2);
      rd_en     = (rd_addr_c < count_r);
    end
  end
  assign rd_addr = rd_addr_c[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_data_r;
    if (ctrl.enq_write) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = {prio_in_r, data_in_r};
    end else if (ctrl.shift_step) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (ctrl.scan_start) idx_nxt = '0;
    else if (ctrl.scan_step || ctrl.shift_step) idx_nxt = idx_r + AW'(1);
    else if (ctrl.shift_start) idx_nxt = best_idx_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq_write) count_nxt = count_r + CW'(1);
    else if (ctrl.count_dec) count_nxt = count_m1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctrl.latch_in) begin
      cmd_r     <= in_command;
      data_in_r <= in_item_data;
      prio_in_r <= in_item_priority;
    end
    if (take) begin
      best_idx_r  <= idx_r;
      best_data_r <= rd_val;
      best_prio_r <= rd_prio;
    end
    if (ctrl.set_status) begin
      res_status_r <= ctrl.status;
      res_data_r   <= '0;
      res_prio_r   <= '0;
    end else if (ctrl.take_best) begin
      res_data_r <= best_data_r;
      res_prio_r <= best_prio_r;
    end
    if (ctrl.load_out) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_prio_r   <= res_prio_r;
      out_count_r  <= count_wide[apq_pkg::COUNT_W-1:0];
    end
  end

  assign count_wide = (CW + apq_pkg::COUNT_W)'(count_r);

  assign out_status      = out_status_r;
  assign out_data        = out_data_r;
  assign out_priority    = out_prio_r;
  assign out_entry_count = out_count_r;

endmodule

[rtl/array_priority_queue.sv]
// Top level of the unsorted-array max priority queue.
`timescale 1ns / 1ps
// Enqueue requests, and requests that meet a full or empty queue, go straight from decode
// to result. A dequeue scans for the max priority with one memory read per cycle, then,
// unless the winner was the last entry, closes the gap with one read/write per cycle.
// One request is worked at a time; the next is taken as soon as the result goes valid,
// and the output register lets it in while a result waits. Reset (rst_n low, synchronous)
// empties the queue and drops any result.

module array_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] item_data, [47:32] item_priority
  input  logic [0:0]  in_tuser,   // [0] command (0 enqueue, 1 dequeue)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] out_data, [47:32] out_priority,
                                  // [52:48] entry_count, [55:53] zero
  output logic [1:0]  out_tuser   // [1:0] status (0 ok, 1 overflow, 2 underflow)
);

  apq_pkg::ctrl_t ctrl;
  apq_pkg::stat_t stat;

  logic [apq_pkg::STATUS_W-1:0]       status;
  logic signed [apq_pkg::DATA_W-1:0]  res_data;
  logic signed [apq_pkg::PRIO_W-1:0]  res_prio;
  logic [apq_pkg::COUNT_W-1:0]        entry_count;

  // Sequencer: accept, decode, scan, shift, hand off result.
  apq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  // Entry store plus compare/shift logic and the output register.
  apq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_command       (in_tuser[0]),
    .in_item_data     (in_tdata[31:0]),
    .in_item_priority (in_tdata[47:32]),
    .out_status       (status),
    .out_data         (res_data),
    .out_priority     (res_prio),
    .out_entry_count  (entry_count)
  );

  assign out_tdata = {3'b000, entry_count, res_prio, res_data};
  assign out_tuser = status;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the array priority queue: directed and random requests.
`timescale 1ns / 1ps

module tb_top;

  localparam int QDEPTH = 16;

  // receiver stall patterns
  localparam int RX_ALWAYS      = 0;
  localparam int RX_EVERY_THIRD = 1;
  localparam int RX_RANDOM      = 2;
  localparam int RX_LONG        = 3;

  // priority styles for random requests
  localparam int PRIO_NARROW  = 0;  // -3..3, lots of ties
  localparam int PRIO_FULL    = 1;
  localparam int PRIO_CORNERS = 2;

  typedef struct packed {
    logic [apq_pkg::STATUS_W-1:0] status;
    logic [apq_pkg::DATA_W-1:0]   data;
    logic [apq_pkg::PRIO_W-1:0]   prio;
    logic [apq_pkg::COUNT_W-1:0]  count;
  } pq_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  // shadow copy of the queue contents
  logic [apq_pkg::DATA_W-1:0]        shadow_data [QDEPTH];
  logic signed [apq_pkg::PRIO_W-1:0] shadow_prio [QDEPTH];
  int                                shadow_count;

  pq_result_t pending_results[$];
  int         error_count;
  int         burst_left;
  bit         sender_steady;
  int         rx_mode;
  int         rx_cycle;

  array_priority_queue #(.DEPTH(QDEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Apply one request to the shadow queue and return what the block must answer.
  function automatic pq_result_t queue_apply(logic cmd, logic [apq_pkg::DATA_W-1:0] data,
                                             logic [apq_pkg::PRIO_W-1:0] prio);
    pq_result_t r;
    int         best;
    r = '0;
    r.status = apq_pkg::ST_OK;
    if (cmd == apq_pkg::CMD_ENQUEUE) begin
      if (shadow_count >= QDEPTH) begin
        r.status = apq_pkg::ST_OVERFLOW;
      end else begin
        shadow_data[shadow_count] = data;
        shadow_prio[shadow_count] = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = apq_pkg::ST_UNDERFLOW;
    end else begin
      // strict greater-than keeps the earliest entry on ties
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_prio[i] > shadow_prio[best]) best = i;
      end
      r.data = shadow_data[best];
      r.prio = shadow_prio[best];
      for (int i = best; i + 1 < shadow_count; i++) begin
        shadow_data[i] = shadow_data[i + 1];
        shadow_prio[i] = shadow_prio[i + 1];
      end
      shadow_count--;
    end
    r.count = shadow_count[apq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Present one request, wait for the handshake, record the expected answer.
  // Called on a rising edge; returns on the edge where the request was taken.
  task automatic send_request(input logic cmd, input logic [apq_pkg::DATA_W-1:0] data,
                              input logic [apq_pkg::PRIO_W-1:0] prio);
    int gap;
    if (burst_left == 0) begin
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {prio, data};
    in_tuser  <= cmd;
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(queue_apply(cmd, data, prio));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%h", $time,
                 out_tuser, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("data", 32'(want.data), 32'(out_tdata[31:0]));
        check_field("priority", 32'(want.prio), 32'(out_tdata[47:32]));
        check_field("count", 32'(want.count), 32'(out_tdata[52:48]));
      end
    end
  end

  // Receiver back-pressure, switching between the stall patterns at random.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_mode)
      RX_ALWAYS:      out_tready <= 1'b1;
      RX_EVERY_THIRD: out_tready <= (rx_cycle % 3) != 0;
      RX_RANDOM:      out_tready <= 1'($urandom_range(0, 1));
      default:        out_tready <= (rx_cycle % 32) < 20;
    endcase
    if (rx_cycle % 256 == 255) rx_mode <= $urandom_range(RX_ALWAYS, RX_LONG);
  end

  task automatic test_empty_dequeue();
    // ignored fields at both extremes
    send_request(apq_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(apq_pkg::CMD_DEQUEUE, 32'h0000_0000, 16'h0000);
  endtask

  task automatic test_fill_overflow();
    logic [apq_pkg::PRIO_W-1:0] prios [QDEPTH] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                                    16'h7FFF, 16'h8000, 16'h0001, 16'h7FFE,
                                                    16'h0000, 16'hFFFF, 16'h7FFF, 16'h1234,
                                                    16'h8001, 16'h0000, 16'h4000, 16'hC000};
    logic [apq_pkg::DATA_W-1:0] datas [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                              32'hFFFF_FFFF};
    for (int i = 0; i < QDEPTH; i++) begin
      send_request(apq_pkg::CMD_ENQUEUE, (i < 4) ? datas[i] : $urandom, prios[i]);
    end
    send_request(apq_pkg::CMD_ENQUEUE, $urandom, 16'h7FFF);  // full: overflow
  endtask

  task automatic test_tie_order();
    // three entries share the top priority; earliest must leave first
    repeat (4) send_request(apq_pkg::CMD_DEQUEUE, $urandom, 16'($urandom));
    send_request(apq_pkg::CMD_ENQUEUE, $urandom, 16'h7FFF);
    send_request(apq_pkg::CMD_DEQUEUE, $urandom, 16'($urandom));
  endtask

  task automatic test_random_traffic(input int n_items);
    int                         enq_pct;
    int                         prio_style;
    int                         phase_left;
    int                         style;
    logic                       cmd;
    logic [apq_pkg::PRIO_W-1:0] prio;
    phase_left = 0;
    enq_pct    = 50;
    prio_style = PRIO_FULL;
    for (int k = 0; k < n_items; k++) begin
      if (phase_left == 0) begin
        // phases lean toward filling, draining or balance so full and empty both occur
        phase_left = $urandom_range(40, 120);
        case ($urandom_range(0, 3))
          0:       enq_pct = 85;
          1:       enq_pct = 50;
          2:       enq_pct = 20;
          default: enq_pct = $urandom_range(0, 100);
        endcase
        prio_style    = $urandom_range(PRIO_NARROW, PRIO_CORNERS + 1);
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      cmd   = ($urandom_range(0, 99) < enq_pct) ? apq_pkg::CMD_ENQUEUE : apq_pkg::CMD_DEQUEUE;
      style = (prio_style > PRIO_CORNERS) ? $urandom_range(PRIO_NARROW, PRIO_CORNERS)
                                          : prio_style;
      case (style)
        PRIO_NARROW: prio = 16'($urandom_range(0, 6)) - 16'd3;
        PRIO_FULL:   prio = 16'($urandom);
        default: begin
          case ($urandom_range(0, 3))
            0:       prio = 16'h7FFF;
            1:       prio = 16'h8000;
            2:       prio = 16'h0000;
            default: prio = 16'hFFFF;
          endcase
        end
      endcase
      send_request(cmd, $urandom, prio);
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    // hold off until every answer is back, then hit the idle block back to back
    wait_drained();
    sender_steady = 1'b1;
    burst_left    = 0;
    repeat (3) send_request(apq_pkg::CMD_DEQUEUE, $urandom, 16'($urandom));
    repeat (3) send_request(apq_pkg::CMD_ENQUEUE, $urandom, 16'($urandom));
    sender_steady = 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= '0;
    out_tready    <= 1'b0;
    rx_mode        = RX_ALWAYS;
    rx_cycle       = 0;
    shadow_count   = 0;
    error_count    = 0;
    burst_left     = 0;
    sender_steady  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_dequeue();
    test_fill_overflow();
    test_tie_order();
    test_random_traffic(575);
    test_drain_pause();
    test_random_traffic(575);

    wait_drained();
    repeat (80) @(posedge clk);  // catch any stray result after the last answer
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[array_priority_queue.f]
rtl/apq_pkg.sv
rtl/apq_ctrl.sv
rtl/apq_datapath.sv
rtl/array_priority_queue.sv
tb/tb_top.sv
